// ----- design/qsl_pkg.sv -----
// ----------------------------------------------------------------------------
// qsl_pkg
// Shared constants and types of the quicksort sorter: store depth, index
// widths and the range record kept on the range stack.
// ----------------------------------------------------------------------------
package qsl_pkg;

   // Number of entries in the element store and in the range stack.
   localparam int DEPTH   = 64;
   // Width of one element.
   localparam int DATA_W  = 32;
   // Width of an index into the store.
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Width of a counter that can also hold DEPTH itself.
   localparam int CNT_W   = $clog2(DEPTH + 1);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   // One pending index range of the sort.
   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

endpackage

// ----- design/qsl_req_if.sv -----
// ----------------------------------------------------------------------------
// qsl_req_if / qsl_rsp_if
// Valid/ready channels of the quicksort sorter: the element input and the
// sorted result output.
// ----------------------------------------------------------------------------
interface qsl_req_if
   import qsl_pkg::*;
();
   logic     valid;
   logic     ready;
   data_type value;
   logic     last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface qsl_rsp_if
   import qsl_pkg::*;
();
   logic     valid;
   logic     ready;
   data_type sorted_value;
   logic     final_res;
   logic     overflowed;

   modport source (output valid, output sorted_value, output final_res,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input final_res,
                   input overflowed, output ready);
endinterface

// ----- design/quicksort_lomuto_sorter.sv -----
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter
// Collects signed 32-bit elements, sorts them in place by quicksort with a
// first-element pivot and a Lomuto partition, and streams them out sorted.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one element per beat; the beat with last set closes the
//    set and starts the sort. Up to DEPTH elements are kept, further ones
//    are dropped and flagged as overflowed on every result of that set.
//  - rsp_if then returns one beat per stored element in ascending order,
//    final_res set on the last one.
//  - Loading takes each element as offered. The sort runs on one shared
//    compare unit over an element memory with one write and one read port
//    and registered read: pop a range, fetch its pivot, compare each
//    element (a swap adds a step), place the pivot, push the sub-ranges;
//    about N log2 N compares on average, N*N/2 worst (already sorted input).
//  - Each result is read from memory into the output register, which holds
//    its beat while the receiver stalls.
//  - req_if.ready is high only while loading; no element is taken from the
//    last beat of a set until its final result has been taken.
//  - Synchronous reset empties the store, the range stack and the overflow
//    flag and returns the block to loading. No clearing pass is needed.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter
   import qsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   qsl_req_if.sink    req_if,
   qsl_rsp_if.source  rsp_if
);

   // Sequencer states, one-hot.
   typedef enum logic [11:0] {
      S_LOAD   = 12'b0000_0000_0001,
      S_START  = 12'b0000_0000_0010,
      S_POP    = 12'b0000_0000_0100,
      S_RANGE  = 12'b0000_0000_1000,
      S_KEY    = 12'b0000_0001_0000,
      S_CMP    = 12'b0000_0010_0000,
      S_SWAP   = 12'b0000_0100_0000,
      S_FIN    = 12'b0000_1000_0000,
      S_FIN2   = 12'b0001_0000_0000,
      S_PUSH2  = 12'b0010_0000_0000,
      S_OUT_RD = 12'b0100_0000_0000,
      S_OUT_V  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   cnt_type   sp_ff, sp_in;
   logic      ovf_ff, ovf_in;
   idx_type   lo_ff, lo_in;
   idx_type   hi_ff, hi_in;
   idx_type   mark_ff, mark_in;
   idx_type   cur_ff, cur_in;
   idx_type   k_ff, k_in;
   data_type  key_ff, key_in;

   // Element store and range stack, each with one write and one read port.
   data_type  elem_mem [DEPTH];
   data_type  elem_rd_ff;
   range_type stk_mem [DEPTH];
   range_type stk_rd_ff;

   logic      elem_we;
   idx_type   elem_waddr;
   data_type  elem_wdata;
   idx_type   elem_raddr;
   logic      stk_we;
   idx_type   stk_waddr;
   range_type stk_wdata;
   idx_type   stk_raddr;

   logic      req_fire;
   logic      rsp_fire;
   logic      is_less;
   idx_type   mark_next;
   idx_type   cur_next;
   cnt_type   sp_dec;

   assign req_fire  = req_if.valid && req_if.ready;
   assign rsp_fire  = rsp_if.valid && rsp_if.ready;
   // The shared compare unit: current element against the pivot.
   assign is_less   = elem_rd_ff < key_ff;
   assign mark_next = mark_ff + idx_type'(1);
   assign cur_next  = cur_ff + idx_type'(1);
   assign sp_dec    = sp_ff - cnt_type'(1);

   // Channel outputs.
   assign req_if.ready        = (state_ff == S_LOAD);
   assign rsp_if.valid        = (state_ff == S_OUT_V);
   assign rsp_if.sorted_value = elem_rd_ff;
   assign rsp_if.final_res    = ({1'b0, k_ff} == count_ff - cnt_type'(1));
   assign rsp_if.overflowed   = ovf_ff;

   // Sequencer: loading, partition steps, stack handling and read-out.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      sp_in      = sp_ff;
      ovf_in     = ovf_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mark_in    = mark_ff;
      cur_in     = cur_ff;
      k_in       = k_ff;
      key_in     = key_ff;
      elem_we    = 1'b0;
      elem_waddr = count_ff[IDX_W-1:0];
      elem_wdata = req_if.value;
      elem_raddr = k_ff;
      stk_we     = 1'b0;
      stk_waddr  = sp_ff[IDX_W-1:0];
      stk_wdata  = '{lo: lo_ff, hi: mark_ff - idx_type'(1)};
      stk_raddr  = sp_dec[IDX_W-1:0];

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < cnt_type'(DEPTH)) begin
                  elem_we  = 1'b1;
                  count_in = count_ff + cnt_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_if.last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            // The whole set is the first range when it has two or more elements.
            sp_in = '0;
            if (count_ff >= cnt_type'(2)) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = '{lo: '0, hi: idx_type'(count_ff - cnt_type'(1))};
               sp_in     = cnt_type'(1);
            end
            state_in = S_POP;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               sp_in    = sp_dec;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            // Range just popped; fetch its pivot.
            lo_in      = stk_rd_ff.lo;
            hi_in      = stk_rd_ff.hi;
            elem_raddr = stk_rd_ff.lo;
            if (stk_rd_ff.lo >= stk_rd_ff.hi) begin
               state_in = S_POP;
            end else begin
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            key_in     = elem_rd_ff;
            mark_in    = lo_ff;
            cur_in     = lo_ff + idx_type'(1);
            elem_raddr = lo_ff + idx_type'(1);
            state_in   = S_CMP;
         end
         S_CMP: begin
            // A smaller element moves down to just past the mark; the old
            // entry there is read out in the same cycle and put back at cur.
            if (is_less && (mark_next != cur_ff)) begin
               elem_raddr = mark_next;
               elem_we    = 1'b1;
               elem_waddr = mark_next;
               elem_wdata = elem_rd_ff;
               mark_in    = mark_next;
               state_in   = S_SWAP;
            end else begin
               if (is_less) begin
                  mark_in = mark_next;
               end
               elem_raddr = cur_next;
               if (cur_ff == hi_ff) begin
                  state_in = S_FIN;
               end else begin
                  cur_in = cur_next;
               end
            end
         end
         S_SWAP: begin
            elem_we    = 1'b1;
            elem_waddr = cur_ff;
            elem_wdata = elem_rd_ff;
            elem_raddr = cur_next;
            if (cur_ff == hi_ff) begin
               state_in = S_FIN;
            end else begin
               cur_in   = cur_next;
               state_in = S_CMP;
            end
         end
         S_FIN: begin
            // Pivot goes to the mark; the entry there goes to lo next cycle.
            elem_raddr = mark_ff;
            elem_we    = 1'b1;
            elem_waddr = mark_ff;
            elem_wdata = key_ff;
            state_in   = S_FIN2;
         end
         S_FIN2: begin
            elem_we    = 1'b1;
            elem_waddr = lo_ff;
            elem_wdata = elem_rd_ff;
            stk_wdata  = '{lo: lo_ff, hi: mark_ff - idx_type'(1)};
            if (({1'b0, mark_ff} > ({1'b0, lo_ff} + cnt_type'(1)))
                && (sp_ff < cnt_type'(DEPTH))) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + cnt_type'(1);
            end
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            stk_wdata = '{lo: mark_next, hi: hi_ff};
            if (({1'b0, hi_ff} > ({1'b0, mark_ff} + cnt_type'(1)))
                && (sp_ff < cnt_type'(DEPTH))) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + cnt_type'(1);
            end
            state_in = S_POP;
         end
         S_OUT_RD: begin
            state_in = S_OUT_V;
         end
         S_OUT_V: begin
            // Read address stays on k so the registered data holds while stalled.
            if (rsp_fire) begin
               if (rsp_if.final_res) begin
                  count_in = '0;
                  sp_in    = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + idx_type'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         sp_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sp_ff    <= sp_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Working registers of the partition and read-out.
   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mark_ff <= mark_in;
      cur_ff  <= cur_in;
      k_ff    <= k_in;
      key_ff  <= key_in;
   end

   // Element store: read returns the value held before a same-cycle write.
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= elem_wdata;
      end
      elem_rd_ff <= elem_mem[elem_raddr];
   end

   // Range stack.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

endmodule

// ----- design/qsl_checker.sv -----
// ----------------------------------------------------------------------------
// qsl_checker
// Port-level checks of the quicksort sorter, bound to the top level.
// ----------------------------------------------------------------------------
module qsl_checker
   import qsl_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_final
);

   // Loading and read-out never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is offered");

   // The block comes out of reset ready to load.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready after reset");

   // Input ready drops after a closing beat.
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("still loading after the last beat");

   // The final result beat returns the block to loading.
   a_final_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final) |=> (req_ready && !rsp_valid))
      else $error("not back to loading after the final result");

   // Loading does not resume after a result beat that is not final.
   a_more_results: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_final) |=> !req_ready)
      else $error("loading resumed before the final result");

endmodule

bind quicksort_lomuto_sorter qsl_checker u_qsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_last  (req_if.last),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_final (rsp_if.final_res)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quicksort sorter. Sets of signed elements are
// streamed in over the request channel. A local quicksort with a first-element
// pivot predicts the sorted beats of each set, and every result beat is
// compared field by field with the oldest prediction. The sender idles in
// bursts and the receiver stalls on patterns of its own, with one long hold.
// ----------------------------------------------------------------------------
module tb;
   import qsl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 48;
   localparam int TAIL_CYCLES  = 50;
   localparam int LONG_HOLD    = 400;

   // One predicted result beat.
   typedef struct {
      data_type sorted_value;
      logic     final_res;
      logic     overflowed;
   } sorted_beat_type;

   // Stall patterns of the receiver.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_ALTERNATE,
      RX_RANDOM,
      RX_BURSTY
   } rx_mode_type;

   logic clock;
   logic reset;

   qsl_req_if req_bus ();
   qsl_rsp_if rsp_bus ();

   quicksort_lomuto_sorter uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Predictor state: the elements of the set being collected.
   data_type        held [DEPTH];
   cnt_type         held_count;
   logic            dropped;
   sorted_beat_type sorted_due [$];

   int          fault_count;
   int          cycle_count;
   int          burst_left;
   bit          sender_steady;
   bit          long_hold_request;
   int          stall_left;
   int          pattern_tick;
   rx_mode_type rx_mode;

   // Clock.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Sorts the held elements in place: first element of each range as the
   // pivot, one Lomuto pass, pending ranges kept on a stack.
   function automatic void quicksort_held();
      range_type pending [$];
      range_type span;
      data_type  pivot;
      data_type  t;
      int        lo;
      int        hi;
      int        mark;
      if (held_count >= 2)
         pending.push_back('{lo: idx_type'(0), hi: idx_type'(held_count - 1)});
      while (pending.size() > 0) begin
         span  = pending.pop_back();
         lo    = span.lo;
         hi    = span.hi;
         pivot = held[lo];
         mark  = lo;
         for (int cur = lo + 1; cur <= hi; cur++) begin
            if (held[cur] < pivot) begin
               mark++;
               t          = held[cur];
               held[cur]  = held[mark];
               held[mark] = t;
            end
         end
         t          = held[mark];
         held[mark] = held[lo];
         held[lo]   = t;
         // Ranges of fewer than two elements are not pushed.
         if (mark - 1 > lo)
            pending.push_back('{lo: idx_type'(lo), hi: idx_type'(mark - 1)});
         if (hi > mark + 1)
            pending.push_back('{lo: idx_type'(mark + 1), hi: idx_type'(hi)});
      end
   endfunction

   // Takes one accepted element into the prediction; the last one of a set
   // sorts the set and queues its result beats.
   function automatic void record_element(data_type v, logic lst);
      sorted_beat_type beat;
      if (held_count < DEPTH) begin
         held[held_count[IDX_W-1:0]] = v;
         held_count++;
      end else begin
         dropped = 1'b1;
      end
      if (lst) begin
         quicksort_held();
         for (int k = 0; k < held_count; k++) begin
            beat.sorted_value = held[k];
            beat.final_res    = (k == held_count - 1);
            beat.overflowed   = dropped;
            sorted_due.push_back(beat);
         end
         held_count = '0;
         dropped    = 1'b0;
      end
   endfunction

   // A random element: mostly full-range, some extremes, some near zero so
   // that equal values turn up.
   function automatic data_type random_element();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return ($urandom_range(0, 1) == 1) ? data_type'(32'h7FFF_FFFF)
                                           : data_type'(32'h8000_0000);
      else if (pick <= 2)
         return data_type'($urandom_range(0, 8)) - data_type'(4);
      else
         return data_type'($urandom());
   endfunction

   // Offers one element and waits until it is taken. Valid is only lowered
   // when a gap is due, so it never toggles within one step.
   task automatic send_element(input data_type v, input logic lst);
      int gap;
      bit taken;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = sender_steady ? 0 : $urandom_range(0, 5);
      end
      burst_left--;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      req_bus.last  <= lst;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      record_element(v, lst);
   endtask

   // Sends a whole set, last set on the final element.
   task automatic send_set(input data_type vals [$]);
      foreach (vals[i])
         send_element(vals[i], i == vals.size() - 1);
   endtask

   // Holds the sender until every predicted beat has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sorted_due.size() > 0)
         @(posedge clock);
   endtask

   task automatic test_lone_element();
      data_type vals [$];
      vals = {data_type'(-1)};
      send_set(vals);
      vals = {data_type'(9), data_type'(-9)};
      send_set(vals);
   endtask

   task automatic test_extreme_values();
      data_type vals [$];
      vals = {data_type'(32'h7FFF_FFFF), data_type'(32'h8000_0000), data_type'(0),
              data_type'(-1), data_type'(1), data_type'(32'h8000_0000),
              data_type'(32'h7FFF_FFFF)};
      send_set(vals);
   endtask

   task automatic test_equal_values();
      data_type vals [$];
      vals = {data_type'(42), data_type'(42), data_type'(42), data_type'(42),
              data_type'(42)};
      send_set(vals);
   endtask

   task automatic test_reversed_run();
      data_type vals [$];
      for (int i = 0; i < 6; i++)
         vals.push_back(data_type'(100 - 7 * i));
      send_set(vals);
   endtask

   // A full store of ascending elements, the slowest case of a first-element
   // pivot, followed by one more element as a dropped last beat.
   task automatic test_overflow();
      data_type vals [$];
      for (int i = 0; i < DEPTH; i++)
         vals.push_back(data_type'(i * 3 - 90));
      vals.push_back(random_element());
      send_set(vals);
      wait_drained();
   endtask

   // The receiver holds off for a long time while the sender keeps offering
   // the next set, so the block stalls its input.
   task automatic test_output_backpressure();
      data_type vals [$];
      long_hold_request = 1'b1;
      sender_steady     = 1'b1;
      for (int i = 0; i < 12; i++)
         vals.push_back(random_element());
      send_set(vals);
      vals = {};
      for (int i = 0; i < 4; i++)
         vals.push_back(random_element());
      send_set(vals);
      sender_steady = 1'b0;
      wait_drained();
   endtask

   // Random sets, mostly small, now and then large.
   task automatic test_random_sets();
      data_type vals [$];
      int       sent;
      int       size_pick;
      int       set_size;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         size_pick = $urandom_range(0, 19);
         if (size_pick < 16)
            set_size = $urandom_range(1, 10);
         else if (size_pick < 19)
            set_size = $urandom_range(11, 40);
         else
            set_size = $urandom_range(41, DEPTH + 6);
         if (set_size > RANDOM_ITEMS - sent)
            set_size = RANDOM_ITEMS - sent;
         sender_steady = ($urandom_range(0, 3) == 0);
         vals = {};
         for (int i = 0; i < set_size; i++)
            vals.push_back(random_element());
         send_set(vals);
         sent += set_size;
         if ($urandom_range(0, 4) == 0)
            wait_drained();
      end
      sender_steady = 1'b0;
   endtask

   // Receiver: draws its stall pattern anew on a pattern_tick boundary, and
   // serves a long hold when one is requested.
   always @(posedge clock) begin
      pattern_tick++;
      if (long_hold_request) begin
         long_hold_request = 1'b0;
         stall_left        = LONG_HOLD;
      end
      if (pattern_tick % 64 == 0)
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:      rsp_bus.ready <= 1'b1;
            RX_ALTERNATE: rsp_bus.ready <= pattern_tick[0];
            RX_RANDOM:    rsp_bus.ready <= ($urandom_range(0, 2) != 0);
            default:      rsp_bus.ready <= (pattern_tick[3:2] != 2'b00);
         endcase
      end
   end

   // Checker: both sides are stable at the falling edge, and a beat seen
   // there is taken at the next rising edge.
   always @(negedge clock) begin
      sorted_beat_type due;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (sorted_due.size() == 0) begin
            $error("unexpected result beat: sorted_value %0d", rsp_bus.sorted_value);
            fault_count++;
         end else begin
            due = sorted_due.pop_front();
            if (rsp_bus.sorted_value !== due.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      due.sorted_value, rsp_bus.sorted_value);
               fault_count++;
            end
            if (rsp_bus.final_res !== due.final_res) begin
               $error("final_res: expected %0b, actual %0b",
                      due.final_res, rsp_bus.final_res);
               fault_count++;
            end
            if (rsp_bus.overflowed !== due.overflowed) begin
               $error("overflowed: expected %0b, actual %0b",
                      due.overflowed, rsp_bus.overflowed);
               fault_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset             = 1'b1;
      held_count        = '0;
      dropped           = 1'b0;
      fault_count       = 0;
      cycle_count       = 0;
      burst_left        = 0;
      sender_steady     = 1'b0;
      long_hold_request = 1'b0;
      stall_left        = 0;
      pattern_tick      = 0;
      rx_mode           = RX_OPEN;
      req_bus.valid    <= 1'b0;
      req_bus.value    <= '0;
      req_bus.last     <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lone_element();
      test_extreme_values();
      test_equal_values();
      test_reversed_run();
      wait_drained();
      test_overflow();
      test_output_backpressure();
      test_random_sets();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sorted_due.size() != 0)
         $error("%0d predicted beats never arrived", sorted_due.size());
      if (fault_count == 0 && sorted_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
design/qsl_pkg.sv
design/qsl_req_if.sv
design/quicksort_lomuto_sorter.sv
design/qsl_checker.sv
bench/tb.sv
